// ===== rtl/sce_pkg.sv =====
// shared constants and types for the cumulative seam energy block
package sce_pkg;

    localparam int MAX_WIDTH   = 2048;
    localparam int SUM_BITS    = 31;
    localparam int ENERGY_BITS = 16;
    localparam int PATH_BITS   = 31;
    localparam int WIDTH_BITS  = 12;
    localparam int COL_BITS    = $clog2(MAX_WIDTH);
    localparam int CMP_BITS    = ((COL_BITS > WIDTH_BITS) ? COL_BITS : WIDTH_BITS) + 1;

    typedef logic [SUM_BITS-1:0]    t_sum;
    typedef logic [ENERGY_BITS-1:0] t_energy;
    typedef logic [PATH_BITS-1:0]   t_path;
    typedef logic [WIDTH_BITS-1:0]  t_width;
    typedef logic [COL_BITS-1:0]    t_col;
    typedef logic [CMP_BITS-1:0]    t_cmp;

    localparam t_width WIDTH_RESET = WIDTH_BITS'(MAX_WIDTH);
    localparam t_cmp   MAX_WIDTH_C = CMP_BITS'(MAX_WIDTH);
    localparam t_sum   SUM_MAX     = '1;

endpackage

// ===== rtl/sce_in_if.sv =====
// energy pixel stream channel
interface sce_in_if
    import sce_pkg::*;
();
    logic    valid;
    logic    ready;
    t_energy energy;
    logic    frame_start;

    modport source (output valid, output energy, output frame_start, input ready);
    modport sink   (input valid, input energy, input frame_start, output ready);
endinterface

// ===== rtl/sce_out_if.sv =====
// cumulative path sum stream channel
interface sce_out_if
    import sce_pkg::*;
();
    logic  valid;
    logic  ready;
    t_path path_sum;
    logic  row_end;

    modport source (output valid, output path_sum, output row_end, input ready);
    modport sink   (input valid, input path_sum, input row_end, output ready);
endinterface

// ===== rtl/seam_cumulative_energy.sv =====
// cumulative minimum path energy map for seam carving, one pixel per cycle when not stalled
// usage:
//   i_pix carries energy pixels in raster order, frame_start on row 0,
//   column 0 of a new image; o_sum carries one path sum per pixel in the
//   same order, row_end on the last pixel of each row. row 0 passes energy
//   through; later rows add the minimum of the previous row's sums at
//   columns j-1, j and j+1 (an edge neighbor falls back to the center),
//   saturated at the top of the sum range.
//   i_cfg_we / i_cfg_wdata write image_width (0 acts as 1, values above the
//   line buffer depth act as the depth); the user must write it only while
//   idle, which the block does not enforce; reset is the depth
// pipeline:
//   the line buffer is read into the compute stage at the input transfer,
//   the sum is formed there and loads the output register when it advances.
//   one pixel per cycle unless stalled, one line buffer write and two reads.
// reset and stalls:
//   reset empties both stages, clears the column counter and marks the
//   first row; the line buffer is not cleared and needs no clearing pass.
//   a stalled receiver holds the output register, the middle stage fills
//   and i_pix.ready drops until the output drains.
module seam_cumulative_energy
    import sce_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    sce_in_if.sink          i_pix,
    sce_out_if.source       o_sum,
    input  logic            i_cfg_we,
    input  t_width          i_cfg_wdata
);

    // configuration
    t_width  r_width;

    // row tracking
    t_col    r_col;
    logic    r_first;
    t_sum    r_held;

    // compute stage
    logic    r_s1_valid;
    t_energy r_s1_energy;
    t_col    r_s1_col;
    logic    r_s1_first;
    logic    r_s1_last;
    t_sum    r_rd_c;
    t_sum    r_rd_r;

    // output register
    logic    r_out_valid;
    t_sum    r_out_sum;
    logic    r_out_last;

    // line buffer holding the previous row
    t_sum    mem_row [MAX_WIDTH];

    t_cmp    eff_w;
    t_col    in_col;
    t_col    in_col_r;
    logic    in_first;
    logic    in_last;
    logic    in_acc;
    logic    s1_adv;
    logic    wr_en;
    t_sum    s1_left;
    t_sum    s1_right;
    t_sum    s1_min;
    logic [SUM_BITS:0] s1_wide;
    t_sum    n_sum;

    // effective width: zero acts as one, clamp to buffer depth
    always_comb begin
        eff_w = CMP_BITS'(r_width);
        if (r_width == '0) begin
            eff_w = CMP_BITS'(1);
        end else if (CMP_BITS'(r_width) > MAX_WIDTH_C) begin
            eff_w = MAX_WIDTH_C;
        end
    end

    // handshake: middle stage moves on when the output register is free
    assign s1_adv      = !r_out_valid || o_sum.ready;
    assign i_pix.ready = !r_s1_valid || s1_adv;
    assign in_acc      = i_pix.valid && i_pix.ready;
    assign wr_en       = r_s1_valid && s1_adv;

    // column and row position of the incoming pixel
    assign in_col   = i_pix.frame_start ? '0 : r_col;
    assign in_first = i_pix.frame_start ? 1'b1 : r_first;
    assign in_last  = CMP_BITS'(in_col) >= (eff_w - CMP_BITS'(1));
    assign in_col_r = in_col + COL_BITS'(1);

    // sum for the pixel in the compute stage; left falls back at column 0,
    // right falls back at the row end
    assign s1_left  = (r_s1_col != '0) ? r_held : r_rd_c;
    assign s1_right = r_s1_last ? r_rd_c : r_rd_r;

    always_comb begin
        s1_min = r_rd_c;
        if (s1_left < s1_min) begin
            s1_min = s1_left;
        end
        if (s1_right < s1_min) begin
            s1_min = s1_right;
        end
    end

    always_comb begin
        if (r_s1_first) begin
            s1_wide = (SUM_BITS+1)'(r_s1_energy);
        end else begin
            s1_wide = (SUM_BITS+1)'(r_s1_energy) + {1'b0, s1_min};
        end
        n_sum = s1_wide[SUM_BITS] ? SUM_MAX : s1_wide[SUM_BITS-1:0];
    end

    // line buffer: one write, two reads; a write at the same edge forwards
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_row[r_s1_col] <= n_sum;
        end
        if (in_acc) begin
            r_rd_c <= (wr_en && (r_s1_col == in_col))   ? n_sum : mem_row[in_col];
            r_rd_r <= (wr_en && (r_s1_col == in_col_r)) ? n_sum : mem_row[in_col_r];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= WIDTH_RESET;
            r_col       <= '0;
            r_first     <= 1'b1;
            r_held      <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_width <= i_cfg_wdata;
            end
            if (in_acc) begin
                r_col   <= in_last ? '0 : in_col_r;
                r_first <= in_last ? 1'b0 : in_first;
            end
            // center of the pixel leaving becomes the next pixel's left
            if (wr_en) begin
                r_held <= r_rd_c;
            end
            if (i_pix.ready) begin
                r_s1_valid <= i_pix.valid;
            end
            if (s1_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_energy <= i_pix.energy;
            r_s1_col    <= in_col;
            r_s1_first  <= in_first;
            r_s1_last   <= in_last;
        end
        if (wr_en) begin
            r_out_sum  <= n_sum;
            r_out_last <= r_s1_last;
        end
    end

    assign o_sum.valid    = r_out_valid;
    assign o_sum.path_sum = PATH_BITS'(r_out_sum);
    assign o_sum.row_end  = r_out_last;

    // a stalled compute stage blocks new transfers
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |-> !i_pix.ready)
        else $error("transfer accepted over a stalled compute stage");

    // first row sums pass energy straight through
    a_first_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_first) |-> (n_sum == SUM_BITS'(r_s1_energy)))
        else $error("first row sum differs from energy");

    // column counter steps by one or wraps at the row end
    a_col_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !in_last) |=> (r_col == $past(in_col_r)))
        else $error("column counter did not advance");

    a_col_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && in_last) |=> (r_col == '0 && !r_first))
        else $error("row end did not wrap the column counter");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_s1_valid && !r_out_valid))
        else $error("pipeline not empty after reset");

endmodule

// ===== sim/seam_cumulative_energy_test.sv =====
// self-checking testbench for the cumulative seam energy block
module seam_cumulative_energy_test;
    import sce_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int MODE_ITEMS  = 420;     // random pixels per idling mode
    localparam int OVER_ITEMS  = 64;      // pixels sent with an oversized width
    localparam int HOLD_CYCLES = 400;     // long receiver back-pressure stretch

    // one row of the directed table; known rows carry a hand-computed result
    typedef struct {
        t_width  width;
        t_energy energy;
        logic    start;
        logic    known;
        t_path   path_sum;
        logic    row_end;
    } t_pixel_case;

    typedef struct packed {
        t_path path_sum;
        logic  row_end;
    } t_sum_entry;

    logic   i_clk;
    logic   i_rst_n;
    logic   i_cfg_we;
    t_width i_cfg_wdata;

    sce_in_if  pix_if();
    sce_out_if sum_if();

    seam_cumulative_energy dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix       (pix_if),
        .o_sum       (sum_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // mirror of the block state, advanced once per accepted pixel
    bit [SUM_BITS-1:0] line_sums [MAX_WIDTH];
    int unsigned       col_pos    = 0;
    bit                first_row  = 1'b1;
    bit [SUM_BITS-1:0] left_hold  = '0;
    t_width            width_reg  = WIDTH_RESET;

    t_sum_entry expected_sums [$];
    t_sum_entry next_sum;

    int tx_idle_pct   = 0;
    int rx_idle_pct   = 0;
    int hold_requests = 0;
    int items_sent    = 0;
    int results_seen  = 0;
    int mismatch_count = 0;
    int cycle_count   = 0;
    int frame_pos     = 0;
    int frame_len     = 1;

    // directed table: reset width, mid-row shrink with the column already
    // past the new last one, frame start mid-frame, width one, width zero,
    // growth always paired with a frame start, energy extremes
    t_pixel_case directed_cases [22] = '{
        '{12'd2048, 16'd65535, 1'b0, 1'b1, 31'd65535, 1'b0},
        '{12'd2048, 16'd0,     1'b0, 1'b1, 31'd0,     1'b0},
        '{12'd2048, 16'd40000, 1'b0, 1'b1, 31'd40000, 1'b0},
        '{12'd2,    16'd5,     1'b0, 1'b1, 31'd5,     1'b1},
        '{12'd2,    16'd1,     1'b0, 1'b0, 31'd0,     1'b0},
        '{12'd2,    16'd65535, 1'b0, 1'b0, 31'd0,     1'b0},
        '{12'd2,    16'd9,     1'b1, 1'b1, 31'd9,     1'b0},
        '{12'd2,    16'd0,     1'b0, 1'b1, 31'd0,     1'b1},
        '{12'd2,    16'd65535, 1'b0, 1'b0, 31'd0,     1'b0},
        '{12'd2,    16'd3,     1'b0, 1'b0, 31'd0,     1'b0},
        '{12'd3,    16'd65535, 1'b1, 1'b1, 31'd65535, 1'b0},
        '{12'd3,    16'd7,     1'b0, 1'b1, 31'd7,     1'b0},
        '{12'd3,    16'd65535, 1'b0, 1'b1, 31'd65535, 1'b1},
        '{12'd3,    16'd2,     1'b0, 1'b0, 31'd0,     1'b0},
        '{12'd3,    16'd0,     1'b0, 1'b0, 31'd0,     1'b0},
        '{12'd3,    16'd4,     1'b0, 1'b0, 31'd0,     1'b0},
        '{12'd1,    16'd10,    1'b0, 1'b0, 31'd0,     1'b0},
        '{12'd0,    16'd65535, 1'b0, 1'b0, 31'd0,     1'b0},
        '{12'd1,    16'd11,    1'b1, 1'b1, 31'd11,    1'b1},
        '{12'd1,    16'd1,     1'b0, 1'b0, 31'd0,     1'b0},
        '{12'd2048, 16'd8,     1'b1, 1'b1, 31'd8,     1'b0},
        '{12'd2048, 16'd65535, 1'b0, 1'b1, 31'd65535, 1'b0}
    };

    // clock, period 2
    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // hang guard
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("seam_cumulative_energy regression: fail");
            $finish;
        end
    end

    function automatic int unsigned eff_width(input t_width w);
        if (w == '0)
            return 1;
        if (int'(w) > MAX_WIDTH)
            return MAX_WIDTH;
        return 32'(w);
    endfunction

    // path sum of one pixel: energy plus the cheapest of the three cells
    // above it, edge cells falling back to the center, saturated
    function automatic void predict_pixel(input t_energy e, input logic fs,
                                          output t_path ps, output logic re);
        int unsigned       w;
        int unsigned       col;
        logic              last;
        bit [SUM_BITS-1:0] centre;
        bit [SUM_BITS-1:0] left;
        bit [SUM_BITS-1:0] right;
        bit [SUM_BITS-1:0] best;
        longint            total;
        w = eff_width(width_reg);
        if (fs) begin
            col_pos   = 0;
            first_row = 1'b1;
        end
        col    = (col_pos >= MAX_WIDTH) ? MAX_WIDTH - 1 : col_pos;
        last   = (col >= w - 1);
        centre = line_sums[col];
        left   = (col > 0) ? left_hold : centre;
        right  = (!last && col + 1 < MAX_WIDTH) ? line_sums[col + 1] : centre;
        if (first_row) begin
            total = longint'(e);
        end else begin
            best = centre;
            if (left < best)
                best = left;
            if (right < best)
                best = right;
            total = longint'(e) + longint'(best);
        end
        if (total > longint'(SUM_MAX))
            total = longint'(SUM_MAX);
        left_hold      = centre;
        line_sums[col] = total[SUM_BITS-1:0];
        if (last) begin
            col_pos   = 0;
            first_row = 1'b0;
        end else begin
            col_pos = col + 1;
        end
        ps = total[PATH_BITS-1:0];
        re = last;
    endfunction

    function automatic t_energy pick_energy();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return t_energy'($urandom_range(15));
            default: return t_energy'($urandom);
        endcase
    endfunction

    function automatic t_width pick_width();
        case ($urandom_range(9))
            0:       return 12'd0;
            1:       return 12'd1;
            2:       return 12'd2;
            3:       return 12'd3;
            default: return t_width'($urandom_range(4, 40));
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at result %0d: %s", results_seen, msg);
        mismatch_count++;
    endtask

    // offer one pixel, with random gaps ahead of it; the expected sum is
    // queued at the edge where the transfer happens
    task automatic send_pixel(input t_energy e, input logic fs, input logic known,
                              input t_path k_sum, input logic k_end);
        t_path      ps;
        logic       re;
        t_sum_entry entry;
        while ($urandom_range(99) < tx_idle_pct) begin
            pix_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        pix_if.valid       <= 1'b1;
        pix_if.energy      <= e;
        pix_if.frame_start <= fs;
        @(posedge i_clk);
        while (!pix_if.ready)
            @(posedge i_clk);
        predict_pixel(e, fs, ps, re);
        if (known)
            entry = '{path_sum: k_sum, row_end: k_end};
        else
            entry = '{path_sum: ps, row_end: re};
        expected_sums.push_back(entry);
        items_sent++;
        @(negedge i_clk);
    endtask

    // sender stops until every queued sum has come out, then a short
    // pause to cover the two-stage pipeline
    task automatic wait_idle();
        pix_if.valid <= 1'b0;
        while (expected_sums.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_width(input t_width w);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= w;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        width_reg = w;
    endtask

    // frames of random content; a wider row always restarts the frame so
    // no never-written line buffer word gets read, a narrower one may
    // carry on mid-frame; noise_pct adds stray frame starts
    task automatic run_frames(input t_width w, input int n_items, input int max_rows,
                              input int noise_pct);
        logic fresh;
        logic fs;
        fresh = (eff_width(w) > eff_width(width_reg)) || ($urandom_range(1) == 1);
        set_width(w);
        if (fresh)
            frame_pos = 0;
        repeat (n_items) begin
            fs = (frame_pos == 0) || ($urandom_range(99) < noise_pct);
            if (fs) begin
                frame_pos = 0;
                frame_len = eff_width(w) * $urandom_range(2, max_rows);
            end
            send_pixel(pick_energy(), fs, 1'b0, '0, 1'b0);
            frame_pos++;
            if (frame_pos >= frame_len)
                frame_pos = 0;
        end
    endtask

    // receiver: random stalls, plus a long hold-off whenever one is asked for
    initial begin
        int hold_seen;
        int hold_left;
        hold_seen    = 0;
        hold_left    = 0;
        sum_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_seen != hold_requests) begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                sum_if.ready <= 1'b0;
                hold_left--;
            end else begin
                sum_if.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // result checker, oldest expectation first
    always @(posedge i_clk) begin
        if (i_rst_n && sum_if.valid && sum_if.ready) begin
            if (expected_sums.size() == 0) begin
                report_mismatch($sformatf("unexpected sum %0d row_end %0b",
                                          sum_if.path_sum, sum_if.row_end));
            end else begin
                next_sum = expected_sums.pop_front();
                if (sum_if.path_sum !== next_sum.path_sum)
                    report_mismatch($sformatf("path_sum %0d, expected %0d",
                                              sum_if.path_sum, next_sum.path_sum));
                if (sum_if.row_end !== next_sum.row_end)
                    report_mismatch($sformatf("row_end %0b, expected %0b",
                                              sum_if.row_end, next_sum.row_end));
            end
            results_seen++;
        end
    end

    initial begin
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_wdata        = WIDTH_RESET;
        pix_if.valid       = 1'b0;
        pix_if.energy      = '0;
        pix_if.frame_start = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed table under light idling
        tx_idle_pct = 21;
        rx_idle_pct = 47;
        foreach (directed_cases[i]) begin
            if (directed_cases[i].width != width_reg)
                set_width(directed_cases[i].width);
            send_pixel(directed_cases[i].energy, directed_cases[i].start,
                       directed_cases[i].known, directed_cases[i].path_sum,
                       directed_cases[i].row_end);
        end

        // random frames under three idling patterns
        for (int mode = 0; mode < 3; mode++) begin
            int mode_start;
            case (mode)
                0: begin
                    tx_idle_pct = 21;
                    rx_idle_pct = 47;
                end
                1: begin
                    tx_idle_pct = 47;
                    rx_idle_pct = 21;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            mode_start = items_sent;
            // in modes 0 and 2, a long receiver hold-off while the sender keeps
            // offering; the pipeline drains first so the hold overlaps new traffic
            if (mode != 1) begin
                wait_idle();
                hold_requests++;
            end
            while (items_sent - mode_start < MODE_ITEMS)
                run_frames(pick_width(), $urandom_range(40, 120), 6, 2);
        end

        // oversized width acts as the full line buffer
        wait_idle();
        hold_requests++;
        run_frames(12'd4095, OVER_ITEMS, 2, 0);

        wait_idle();
        repeat (8) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("seam_cumulative_energy regression: pass");
        end else begin
            $display("seam_cumulative_energy regression: fail");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/sce_pkg.sv
rtl/sce_in_if.sv
rtl/sce_out_if.sv
rtl/seam_cumulative_energy.sv
sim/seam_cumulative_energy_test.sv
